FILE: design/awlm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awlm_pkg
// Shared constants and types of the windowed loudness monitor.
// ----------------------------------------------------------------------------
package awlm_pkg;

  localparam int unsigned WinMaxSamples = 8192;
  localparam int unsigned WinCntW       = 14;
  localparam logic [63:0] TotalLimit    = 64'hFFFF_FFFF_0001_FFFD;
  localparam logic [6:0]  ShiftStop     = 7'd126;

  localparam logic [1:0]  FindNone  = 2'd0;
  localparam logic [1:0]  FindLoud  = 2'd1;
  localparam logic [1:0]  FindQuiet = 2'd2;

  localparam logic        CfgHighGain = 1'b0;
  localparam logic        CfgLowGain  = 1'b1;

  // Finished window, handed from the front end to the back end.
  typedef struct packed {
    logic [43:0] sq_sum;
    logic [28:0] val_sum;
    logic [13:0] count;
    logic [14:0] peak;
  } win_t;

  typedef struct packed {
    logic [1:0]  finding;
    logic [15:0] window_rms;
    logic [15:0] overall_rms;
    logic [15:0] overall_dc;
    logic [14:0] window_peak;
  } result_t;

endpackage
`default_nettype wire

FILE: design/awlm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awlm_front
// Accumulates squares, values and peak over a window; emits window totals.
// ----------------------------------------------------------------------------
module awlm_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [15:0]   sample_i,
  input  wire logic                 window_end_i,
  output logic                      win_valid_o,
  input  wire logic                 win_ready_i,
  output awlm_pkg::win_t            win_o
);
  import awlm_pkg::*;

  logic [43:0] sq_q, sq_d;
  logic [28:0] val_q, val_d;
  logic [13:0] cnt_q, cnt_d;
  logic [14:0] peak_q, peak_d;
  logic        pend_q, pend_d;
  // Square is registered first so the multiplier stands alone.
  logic        sv_q;
  logic [31:0] sqr_q;
  logic signed [15:0] smp_q;
  logic        end_q;
  logic [15:0] mag;
  logic [14:0] mag_s;
  logic        close;

  // Accept when the squaring stage is free and no finished window waits.
  assign in_stall_o = sv_q | pend_q;
  assign win_valid_o = pend_q;
  assign win_o = '{sq_sum: sq_q, val_sum: val_q, count: cnt_q, peak: peak_q};

  always_comb begin
    mag   = smp_q[15] ? (16'd0 - smp_q) : smp_q;
    mag_s = mag[15] ? 15'h7FFF : mag[14:0];
    close = end_q | ({1'b0, cnt_q} + 15'd1 >= 15'(WinMaxSamples));
    sq_d = sq_q; val_d = val_q; cnt_d = cnt_q; peak_d = peak_q; pend_d = pend_q;
    if (pend_q && win_ready_i) begin
      pend_d = 1'b0; sq_d = '0; val_d = '0; cnt_d = '0; peak_d = '0;
    end
    if (sv_q) begin
      sq_d   = sq_q + 44'(sqr_q);
      val_d  = val_q + 29'(smp_q);
      cnt_d  = cnt_q + 14'd1;
      peak_d = (mag_s > peak_q) ? mag_s : peak_q;
      pend_d = close;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= '0; val_q <= '0; cnt_q <= '0; peak_q <= '0;
      pend_q <= 1'b0; sv_q <= 1'b0;
    end else begin
      sq_q <= sq_d; val_q <= val_d; cnt_q <= cnt_d; peak_q <= peak_d;
      pend_q <= pend_d;
      sv_q <= in_valid_i && !in_stall_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sqr_q <= 32'($signed(sample_i) * $signed(sample_i));
      smp_q <= sample_i;
      end_q <= window_end_i;
    end
  end
endmodule
`default_nettype wire

FILE: design/awlm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awlm_fifo
// Two-entry queue of finished windows between front and back end.
// ----------------------------------------------------------------------------
module awlm_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_valid_i,
  output logic                 wr_ready_o,
  input  wire awlm_pkg::win_t  wr_data_i,
  output logic                 rd_valid_o,
  input  wire logic            rd_ready_i,
  output awlm_pkg::win_t       rd_data_o
);
  import awlm_pkg::*;

  win_t        mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  fill_q;
  logic        wr, rd;

  assign wr_ready_o = fill_q != 2'd2;
  assign rd_valid_o = fill_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; fill_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      fill_q <= fill_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

FILE: design/awlm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awlm_back
// Folds a window into the totals, then divides and takes square roots
// bit-serially to form the RMS, DC and finding.
// ----------------------------------------------------------------------------
module awlm_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             win_valid_i,
  output logic                  win_ready_o,
  input  wire awlm_pkg::win_t   win_i,
  input  wire logic [15:0]      high_gain_i,
  input  wire logic [15:0]      low_gain_i,
  output logic                  res_valid_o,
  input  wire logic             res_stall_i,
  output awlm_pkg::result_t     res_o
);
  import awlm_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StFold  = 4'd1;
  localparam logic [3:0] StAdd   = 4'd2;
  localparam logic [3:0] StWDiv  = 4'd3;
  localparam logic [3:0] StWSq   = 4'd4;
  localparam logic [3:0] StODiv  = 4'd5;
  localparam logic [3:0] StOScl  = 4'd6;
  localparam logic [3:0] StOSq   = 4'd7;
  localparam logic [3:0] StDDiv  = 4'd8;
  localparam logic [3:0] StMul   = 4'd9;
  localparam logic [3:0] StCmp   = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0]  st_q, st_d;
  win_t        w_q;
  logic [63:0] tsq_q, tval_q, tcnt_q;
  logic [6:0]  tsh_q;
  // Shared divide / square root datapath.
  logic [63:0] num_q, rem_q, quo_q, den_q;
  logic [6:0]  it_q;
  logic [63:0] sv_q, sres_q, sbit_q;
  logic [15:0] wrms_q, orms_q;
  logic [15:0] dc_q;
  logic        neg_q;
  logic [31:0] lhs_q, rhs_h_q, rhs_l_q;
  result_t     res_q;
  logic        rv_q;

  logic [63:0] aligned, sumsq;
  logic [64:0] sum65;
  logic [64:0] rem2;
  logic [63:0] tvabs;
  logic [64:0] sdiff;
  logic [15:0] sq_clamped;
  logic        q_sat;

  assign win_ready_o = (st_q == StIdle);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_comb begin
    aligned = (tsh_q < 7'd64) ? (64'(w_q.sq_sum) >> tsh_q[5:0]) : 64'd0;
    sum65   = {1'b0, tsq_q} + {1'b0, aligned};
    sumsq   = sum65[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum65[63:0];
    rem2    = {rem_q, num_q[63]};
    tvabs   = tval_q[63] ? (64'd0 - tval_q) : tval_q;
    sdiff   = {1'b0, sv_q} - {1'b0, sres_q + sbit_q};
    sq_clamped = (sres_q > 64'd65535) ? 16'hFFFF :
                 (sres_q == 64'd0) ? 16'd1 : sres_q[15:0];
    q_sat   = quo_q >= (64'd1 << 62);
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (win_valid_i) st_d = StFold;
      StFold:  st_d = StAdd;
      StAdd:   st_d = StWDiv;
      StWDiv:  if (it_q == 7'd0) st_d = StWSq;
      StWSq:   if (sbit_q == 64'd0) st_d = StODiv;
      StODiv:  if (it_q == 7'd0) st_d = (tsh_q == 7'd0) ? StOSq : StOScl;
      StOScl:  if (it_q == 7'd0) st_d = StOSq;
      StOSq:   if (sbit_q == 64'd0) st_d = StDDiv;
      StDDiv:  if (it_q == 7'd0) st_d = StMul;
      StMul:   st_d = StCmp;
      StCmp:   st_d = StOut;
      StOut:   if (!rv_q || !res_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; rv_q <= 1'b0;
      tsq_q <= '0; tval_q <= '0; tcnt_q <= '0; tsh_q <= '0;
    end else begin
      st_q <= st_d;
      if (rv_q && !res_stall_i) rv_q <= 1'b0;
      if (st_q == StOut && (!rv_q || !res_stall_i)) rv_q <= 1'b1;
      if (st_q == StFold && tsq_q >= TotalLimit && tsh_q < ShiftStop) begin
        tsq_q <= tsq_q >> 2;
        tsh_q <= tsh_q + 7'd2;
      end
      if (st_q == StAdd) begin
        tsq_q  <= sumsq;
        tval_q <= tval_q + 64'($signed(w_q.val_sum));
        tcnt_q <= tcnt_q + 64'(w_q.count);
      end
    end
  end

  // Restoring division: one quotient bit per cycle over 64 numerator bits.
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (win_valid_i) w_q <= win_i;
      StAdd: begin
        num_q <= 64'(w_q.sq_sum); rem_q <= '0; quo_q <= '0;
        den_q <= 64'(w_q.count); it_q <= 7'd64;
      end
      StWDiv, StODiv, StDDiv: begin
        if (it_q != 7'd0) begin
          num_q <= num_q << 1;
          if (rem2 >= {1'b0, den_q}) begin
            rem_q <= 64'(rem2 - {1'b0, den_q});
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= rem2[63:0];
            quo_q <= {quo_q[62:0], 1'b0};
          end
          it_q <= it_q - 7'd1;
        end else if (st_q == StWDiv) begin
          sv_q <= quo_q; sres_q <= '0; sbit_q <= 64'd1 << 62;
        end else if (st_q == StODiv) begin
          if (tsh_q == 7'd0) begin
            sv_q <= quo_q; sres_q <= '0; sbit_q <= 64'd1 << 62;
          end else begin
            it_q <= tsh_q;
          end
        end else begin
          if (neg_q)
            dc_q <= (quo_q > 64'd32768) ? 16'h8000 : 16'(64'd0 - quo_q);
          else
            dc_q <= (quo_q > 64'd32767) ? 16'h7FFF : quo_q[15:0];
        end
      end
      StOScl: begin
        if (it_q != 7'd0) begin
          if (rem_q >= den_q - rem_q) begin
            rem_q <= rem_q - (den_q - rem_q);
            quo_q <= q_sat ? (64'd1 << 62) : {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= rem_q + rem_q;
            quo_q <= q_sat ? (64'd1 << 62) : {quo_q[62:0], 1'b0};
          end
          it_q <= it_q - 7'd1;
        end else begin
          sv_q <= quo_q; sres_q <= '0; sbit_q <= 64'd1 << 62;
        end
      end
      StWSq, StOSq: begin
        if (sbit_q != 64'd0) begin
          if (!sdiff[64]) begin
            sv_q   <= sdiff[63:0];
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end else if (st_q == StWSq) begin
          wrms_q <= sq_clamped;
          num_q <= tsq_q; rem_q <= '0; quo_q <= '0; it_q <= 7'd64;
          den_q <= (tcnt_q == 64'd0) ? 64'd1 : tcnt_q;
        end else begin
          orms_q <= sq_clamped;
          neg_q <= tval_q[63];
          num_q <= tvabs; rem_q <= '0; quo_q <= '0; it_q <= 7'd64;
        end
      end
      StMul: begin
        lhs_q   <= {wrms_q, 10'd0} & 32'h03FF_FFFF;
        rhs_h_q <= orms_q * high_gain_i;
        rhs_l_q <= orms_q * low_gain_i;
      end
      // Load the output only once the previous result has left.
      StOut: if (!rv_q || !res_stall_i) begin
        res_q.finding     <= (lhs_q >= rhs_h_q) ? FindLoud :
                             (lhs_q <= rhs_l_q) ? FindQuiet : FindNone;
        res_q.window_rms  <= wrms_q;
        res_q.overall_rms <= orms_q;
        res_q.overall_dc  <= dc_q;
        res_q.window_peak <= w_q.peak;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: design/audio_window_loudness_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_window_loudness_monitor
// Windowed RMS level detector with loud / quiet flags.
// ----------------------------------------------------------------------------
// Samples enter on in_valid_i / in_stall_o: the front end squares a sample
// into a register and accumulates it in the next cycle, taking no new sample
// meanwhile; a closing sample stalls input until the queue takes its totals.
// A sample with window_end_i set (or the 8192nd of a window) closes the
// window; the window totals pass through a two-entry queue to the back end,
// which produces one result on out_valid_o / out_stall_i by means of the
// bit-serial divider (three divisions plus the scaling steps) and the two
// 32-step square roots.
// Samples keep flowing while the back end works; beyond its own pacing the
// front end stalls only when the queue is full. A result held by out_stall_i
// stays on the ports unchanged and blocks the back end. Reset clears all sums
// and sets the gains to 2043 and 257. The user must write gains through
// cfg_valid_i / cfg_ready_o only while idle; the block leaves this unchecked.
// ----------------------------------------------------------------------------
module audio_window_loudness_monitor (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] sample_i,
  input  wire logic               window_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              finding_o,
  output logic [15:0]             window_rms_o,
  output logic [15:0]             overall_rms_o,
  output logic signed [15:0]      overall_dc_o,
  output logic [14:0]             window_peak_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);
  import awlm_pkg::*;

  logic [15:0] high_q, low_q;
  logic        fw_valid, fw_ready, bw_valid, bw_ready;
  win_t        fw_data, bw_data;
  result_t     res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q <= 16'd2043;
      low_q  <= 16'd257;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHighGain: high_q <= cfg_data_i;
        CfgLowGain:  low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  awlm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_i, .window_end_i,
    .win_valid_o(fw_valid), .win_ready_i(fw_ready), .win_o(fw_data)
  );

  awlm_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fw_valid), .wr_ready_o(fw_ready), .wr_data_i(fw_data),
    .rd_valid_o(bw_valid), .rd_ready_i(bw_ready), .rd_data_o(bw_data)
  );

  awlm_back u_back (
    .clk_i, .rst_ni,
    .win_valid_i(bw_valid), .win_ready_o(bw_ready), .win_i(bw_data),
    .high_gain_i(high_q), .low_gain_i(low_q),
    .res_valid_o(out_valid_o), .res_stall_i(out_stall_i), .res_o(res)
  );

  assign finding_o     = res.finding;
  assign window_rms_o  = res.window_rms;
  assign overall_rms_o = res.overall_rms;
  assign overall_dc_o  = res.overall_dc;
  assign window_peak_o = res.window_peak;
endmodule
`default_nettype wire
